[rtl/tmwf_pkg.sv]
package tmwf_pkg;

    localparam int SAMPLE_W   = 24;
    // two quotient bits per divide step
    localparam int DIV_STEPS  = SAMPLE_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;    // capture the new sample, seed max, min and sum
        logic scan;    // rotate the history by one place and fold in its tail
        logic insert;  // shift the sample into the history, start the divide
        logic step;    // one radix-4 divide step
        logic emit;    // move the quotient into the output register
    } tmwf_cmd_t;

    typedef struct packed {
        logic out_busy;  // output register holds a beat that is not taken
    } tmwf_status_t;

endpackage

[rtl/tmwf_ctrl.sv]
module tmwf_ctrl #(
    parameter int WINDOW = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tmwf_pkg::tmwf_status_t status,
    output tmwf_pkg::tmwf_cmd_t    cmd
);

    localparam int HIST_DEPTH = WINDOW - 1;
    localparam int CNT_W      = $clog2(HIST_DEPTH);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(HIST_DEPTH - 1);
    localparam logic [tmwf_pkg::DIV_CNT_W-1:0] DIV_LAST =
        tmwf_pkg::DIV_CNT_W'(tmwf_pkg::DIV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INSERT,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                scan_cnt_reg, scan_cnt_next;
    logic [tmwf_pkg::DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        div_cnt_next  = div_cnt_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    scan_cnt_next = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan      = 1'b1;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SCAN_LAST)
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                cmd.insert   = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.step     = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

endmodule

[rtl/tmwf_datapath.sv]
module tmwf_datapath #(
    parameter int WINDOW = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tmwf_pkg::tmwf_cmd_t            cmd,
    output tmwf_pkg::tmwf_status_t         status,
    input  logic [tmwf_pkg::SAMPLE_W-1:0]  sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tmwf_pkg::SAMPLE_W-1:0]  filtered
);

    localparam int SW         = tmwf_pkg::SAMPLE_W;
    localparam int HIST_DEPTH = WINDOW - 1;
    localparam int SUM_W      = SW + $clog2(WINDOW);
    localparam int DIVISOR    = WINDOW - 2;
    localparam int DW         = $clog2(DIVISOR) + 1;
    localparam logic [DW+1:0] D1 = (DW+2)'(DIVISOR);
    localparam logic [DW+1:0] D2 = (DW+2)'(2 * DIVISOR);
    localparam logic [DW+1:0] D3 = (DW+2)'(3 * DIVISOR);

    logic [SW-1:0]    hist_reg [HIST_DEPTH];
    logic [SW-1:0]    sample_reg;
    logic [SW-1:0]    max_reg;
    logic [SW-1:0]    min_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [DW-1:0]    rem_reg;
    logic [SW-1:0]    num_reg;
    logic [SW-1:0]    filtered_reg;
    logic             out_valid_reg;

    logic [SW-1:0]    tail;
    logic [SUM_W-1:0] trimmed;
    logic [DW+1:0]    partial;
    logic [DW+1:0]    sub;
    logic [1:0]       digit;

    assign tail    = hist_reg[HIST_DEPTH-1];
    assign trimmed = sum_reg - SUM_W'(max_reg) - SUM_W'(min_reg);
    assign partial = {rem_reg, num_reg[SW-1:SW-2]};

    // radix-4 restoring step against the fixed divisor multiples
    always_comb
    begin
        priority if (partial >= D3)
        begin
            digit = 2'd3;
            sub   = D3;
        end
        else if (partial >= D2)
        begin
            digit = 2'd2;
            sub   = D2;
        end
        else if (partial >= D1)
        begin
            digit = 2'd1;
            sub   = D1;
        end
        else
        begin
            digit = 2'd0;
            sub   = '0;
        end
    end

    // history is a shift line; a full rotation during the scan returns it to place
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else if (cmd.scan || cmd.insert)
        begin
            hist_reg[0] <= cmd.insert ? sample_reg : tail;
            for (int k = 1; k < HIST_DEPTH; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
            max_reg    <= sample;
            min_reg    <= sample;
            sum_reg    <= SUM_W'(sample);
        end
        else if (cmd.scan)
        begin
            if (tail > max_reg)
            begin
                max_reg <= tail;
            end
            if (tail < min_reg)
            begin
                min_reg <= tail;
            end
            sum_reg <= sum_reg + SUM_W'(tail);
        end

        // quotient fits in the sample width, so the high part starts below the divisor
        if (cmd.insert)
        begin
            rem_reg <= DW'(trimmed[SUM_W-1:SW]);
            num_reg <= trimmed[SW-1:0];
        end
        else if (cmd.step)
        begin
            rem_reg <= DW'(partial - sub);
            num_reg <= {num_reg[SW-3:0], digit};
        end

        if (cmd.emit)
        begin
            filtered_reg <= num_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered        = filtered_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule

[rtl/trimmed_mean_window_filter_top.sv]
// trimmed-mean moving filter for a 24-bit unsigned load-cell stream
// input channel: sample with in_valid / in_ready; output channel: filtered
// with out_valid / out_ready. a beat moves when valid and ready are both high.
// each sample forms a window of WINDOW values with the WINDOW-1 previous ones;
// the result is (sum - max - min) / (WINDOW - 2), truncated.
// one item is worked at a time: the history shift line is rotated once per
// cycle through its tail, an insert step shifts the sample in and forms the
// trimmed sum, and a radix-4 divider then forms the quotient two bits per step.
// a new sample is taken only once the previous result is in the output register.
// in_ready is high only while the block is idle.
// a stalled receiver holds the result in the output register; the next sample
// is still taken and worked, and only its write-back waits for the register.
// reset clears the history to zero, so the first results include those zeros,
// and drops any beat in flight.
module trimmed_mean_window_filter_top #(
    parameter int WINDOW = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] filtered
);

    tmwf_pkg::tmwf_cmd_t    cmd;
    tmwf_pkg::tmwf_status_t status;

    tmwf_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tmwf_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered)
    );

endmodule
